/* src/spet_pkg.sv */
// shared constants and types for the stereo pulse envelope tracker
// no dependencies
package spet_pkg;

    localparam int LEVEL_WIDTH = 16;
    localparam int FRAC_BITS   = 12;
    localparam int VOL_WIDTH   = 13;
    localparam int VOL_FRAC    = 12;
    localparam int DIVD_WIDTH  = LEVEL_WIDTH + VOL_FRAC;
    localparam int CMP_WIDTH   = DIVD_WIDTH + VOL_WIDTH;
    localparam int CNT_WIDTH   = $clog2(LEVEL_WIDTH);
    localparam int TDATA_IN_W  = ((2 * LEVEL_WIDTH + 7) / 8) * 8;
    localparam int TDATA_OUT_W = ((LEVEL_WIDTH + 7) / 8) * 8;

    localparam logic [LEVEL_WIDTH-1:0] LEVEL_MAX = '1;
    localparam logic [LEVEL_WIDTH-1:0] TENTH =
        LEVEL_WIDTH'(((1 << FRAC_BITS) + 5) / 10);
    localparam logic [VOL_WIDTH-1:0]   VOL_ONE = VOL_WIDTH'(1 << VOL_FRAC);

    localparam int BEAT_NUM  = 11;
    localparam int BEAT_DEN  = 10;
    localparam int DECAY_NUM = 93;
    localparam int DECAY_DEN = 100;

    typedef enum logic {
        REG_METER_ENABLE = 1'b0,
        REG_MUSIC_VOLUME = 1'b1
    } reg_index_t;

endpackage

/* src/stereo_pulse_envelope_tracker.sv */
// stereo pulse envelope tracker: volume scaling, beat detection, pulse decay
// depends on spet_pkg; one shared restoring divider under a small sequencer
//
// each word takes one divider pass for each peak and for the pulse; a peak
// pass is skipped when the volume is zero and any pass when its quotient
// saturates; no divider pass is made when metering is disabled or the word is mono
// a new word is taken only after the last result is emitted (m_tready can stall it), set by the single divider
// reset: synchronous active low; state cleared, volume 1.0, metering off
module stereo_pulse_envelope_tracker (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // left_peak [15:0], right_peak [31:16]
    input  logic [spet_pkg::TDATA_IN_W-1:0]      s_tdata,
    // stereo_valid
    input  logic                                 s_tuser,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // pulse_level [15:0]
    output logic [spet_pkg::TDATA_OUT_W-1:0]     m_tdata,
    // updated
    output logic                                 m_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic                                 cfg_we,
    input  logic                                 cfg_index,
    input  logic [spet_pkg::VOL_WIDTH-1:0]       cfg_data
);
    import spet_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD_L,
        S_RUN_L,
        S_LOAD_R,
        S_RUN_R,
        S_CAND,
        S_LOAD_P,
        S_RUN_P,
        S_EMIT
    } state_t;

    state_t                 state_reg;
    logic                   meter_enable_reg;
    logic [VOL_WIDTH-1:0]   music_volume_reg;
    logic [1:0]             ticks_reg;
    logic [LEVEL_WIDTH-1:0] last_pulse_reg;
    logic [LEVEL_WIDTH-1:0] held_avg_reg;

    logic [LEVEL_WIDTH-1:0] left_peak_reg;
    logic [LEVEL_WIDTH-1:0] right_peak_reg;
    logic [LEVEL_WIDTH-1:0] left_q_reg;
    logic [LEVEL_WIDTH-1:0] right_q_reg;
    logic [LEVEL_WIDTH-1:0] cand_reg;
    logic                   beat_reg;
    logic [LEVEL_WIDTH-1:0] pulse_reg;
    logic                   upd_reg;

    logic [VOL_WIDTH-1:0]   rem_reg;
    logic [LEVEL_WIDTH-1:0] low_reg;
    logic [CNT_WIDTH-1:0]   cnt_reg;

    logic                   m_tvalid_reg;
    logic [LEVEL_WIDTH-1:0] m_level_reg;
    logic                   m_upd_reg;

    // divider operands
    logic [DIVD_WIDTH-1:0]  dvd;
    logic [VOL_WIDTH-1:0]   dsr;
    logic                   sat_hit;
    logic [VOL_WIDTH:0]     shv;
    logic                   ge;
    logic [VOL_WIDTH-1:0]   rem_next;
    logic [LEVEL_WIDTH-1:0] low_next;
    logic                   div_done;

    // candidate and beat test
    logic [LEVEL_WIDTH:0]   mean_sum;
    logic [LEVEL_WIDTH:0]   cand_sum;
    logic [LEVEL_WIDTH-1:0] cand_next;
    logic [LEVEL_WIDTH+4:0] cand_x10;
    logic [LEVEL_WIDTH+4:0] last_x11;
    logic [LEVEL_WIDTH+4:0] cand_x20;
    logic [LEVEL_WIDTH+4:0] held_x19;
    logic [LEVEL_WIDTH+4:0] last_x5;
    logic                   beat_next;

    // state update at emit
    logic [LEVEL_WIDTH+3:0] pulse_x10;
    logic                   clear_avg;
    logic [1:0]             ticks_next;
    logic [LEVEL_WIDTH-1:0] held_next;

    always_comb begin
        unique case (state_reg)
            S_LOAD_L, S_RUN_L: begin
                dvd = {left_peak_reg, {VOL_FRAC{1'b0}}};
                dsr = music_volume_reg;
            end
            S_LOAD_R, S_RUN_R: begin
                dvd = {right_peak_reg, {VOL_FRAC{1'b0}}};
                dsr = music_volume_reg;
            end
            default: begin
                if (beat_reg) begin
                    dvd = DIVD_WIDTH'(cand_reg) * DIVD_WIDTH'(BEAT_NUM);
                    dsr = VOL_WIDTH'(BEAT_DEN);
                end else begin
                    dvd = DIVD_WIDTH'(last_pulse_reg) * DIVD_WIDTH'(DECAY_NUM);
                    dsr = VOL_WIDTH'(DECAY_DEN);
                end
            end
        endcase
    end

    assign sat_hit  = CMP_WIDTH'(dvd) >= (CMP_WIDTH'(dsr) << LEVEL_WIDTH);
    assign shv      = {rem_reg, low_reg[LEVEL_WIDTH-1]};
    assign ge       = shv >= {1'b0, dsr};
    assign rem_next = ge ? VOL_WIDTH'(shv - {1'b0, dsr}) : shv[VOL_WIDTH-1:0];
    assign low_next = {low_reg[LEVEL_WIDTH-2:0], ge};
    assign div_done = cnt_reg == CNT_WIDTH'(LEVEL_WIDTH - 1);

    assign mean_sum  = {1'b0, left_q_reg} + {1'b0, right_q_reg};
    assign cand_sum  = {1'b0, mean_sum[LEVEL_WIDTH:1]} + {1'b0, TENTH};
    assign cand_next = cand_sum[LEVEL_WIDTH] ? LEVEL_MAX : cand_sum[LEVEL_WIDTH-1:0];
    assign cand_x10  = (LEVEL_WIDTH+5)'(cand_next) * (LEVEL_WIDTH+5)'(10);
    assign last_x11  = (LEVEL_WIDTH+5)'(last_pulse_reg) * (LEVEL_WIDTH+5)'(11);
    assign cand_x20  = (LEVEL_WIDTH+5)'(cand_next) * (LEVEL_WIDTH+5)'(20);
    assign held_x19  = (LEVEL_WIDTH+5)'(held_avg_reg) * (LEVEL_WIDTH+5)'(19);
    assign last_x5   = (LEVEL_WIDTH+5)'(last_pulse_reg) * (LEVEL_WIDTH+5)'(5);
    assign beat_next = (ticks_reg == 2'd3) && (cand_x10 >= last_x11)
                       && !((cand_x20 < held_x19)
                            && ((LEVEL_WIDTH+5)'(held_avg_reg) < last_x5));

    assign pulse_x10  = (LEVEL_WIDTH+4)'(pulse_reg) * (LEVEL_WIDTH+4)'(10);
    assign clear_avg  = pulse_x10 <= (LEVEL_WIDTH+4)'(1 << FRAC_BITS);
    assign ticks_next = beat_reg ? 2'd1 : ((ticks_reg == 2'd3) ? 2'd3 : ticks_reg + 2'd1);
    assign held_next  = clear_avg ? '0 : (beat_reg ? cand_reg : held_avg_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            meter_enable_reg <= 1'b0;
            music_volume_reg <= VOL_ONE;
            ticks_reg        <= '0;
            last_pulse_reg   <= '0;
            held_avg_reg     <= '0;
            m_tvalid_reg     <= 1'b0;
            cnt_reg          <= '0;
        end else begin
            if (cfg_we) begin
                unique case (reg_index_t'(cfg_index))
                    REG_METER_ENABLE: meter_enable_reg <= cfg_data[0];
                    REG_MUSIC_VOLUME: music_volume_reg <= cfg_data;
                endcase
            end
            if (m_tready && state_reg != S_EMIT) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        left_peak_reg  <= s_tdata[LEVEL_WIDTH-1:0];
                        right_peak_reg <= s_tdata[2*LEVEL_WIDTH-1:LEVEL_WIDTH];
                        if (!meter_enable_reg || !s_tuser) begin
                            pulse_reg <= last_pulse_reg;
                            upd_reg   <= 1'b0;
                            state_reg <= S_EMIT;
                        end else begin
                            upd_reg   <= 1'b1;
                            state_reg <= S_LOAD_L;
                        end
                    end
                end
                S_LOAD_L, S_LOAD_R, S_LOAD_P: begin
                    cnt_reg <= '0;
                    rem_reg <= VOL_WIDTH'(dvd[DIVD_WIDTH-1:LEVEL_WIDTH]);
                    low_reg <= dvd[LEVEL_WIDTH-1:0];
                    priority if (state_reg != S_LOAD_P && dsr == '0) begin
                        if (state_reg == S_LOAD_L) begin
                            left_q_reg <= left_peak_reg;
                            state_reg  <= S_LOAD_R;
                        end else begin
                            right_q_reg <= right_peak_reg;
                            state_reg   <= S_CAND;
                        end
                    end else if (sat_hit) begin
                        unique case (state_reg)
                            S_LOAD_L: begin
                                left_q_reg <= LEVEL_MAX;
                                state_reg  <= S_LOAD_R;
                            end
                            S_LOAD_R: begin
                                right_q_reg <= LEVEL_MAX;
                                state_reg   <= S_CAND;
                            end
                            default: begin
                                pulse_reg <= LEVEL_MAX;
                                state_reg <= S_EMIT;
                            end
                        endcase
                    end else begin
                        unique case (state_reg)
                            S_LOAD_L: state_reg <= S_RUN_L;
                            S_LOAD_R: state_reg <= S_RUN_R;
                            default:  state_reg <= S_RUN_P;
                        endcase
                    end
                end
                S_RUN_L, S_RUN_R, S_RUN_P: begin
                    rem_reg <= rem_next;
                    low_reg <= low_next;
                    cnt_reg <= cnt_reg + CNT_WIDTH'(1);
                    if (div_done) begin
                        unique case (state_reg)
                            S_RUN_L: begin
                                left_q_reg <= low_next;
                                state_reg  <= S_LOAD_R;
                            end
                            S_RUN_R: begin
                                right_q_reg <= low_next;
                                state_reg   <= S_CAND;
                            end
                            default: begin
                                pulse_reg <= low_next;
                                state_reg <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_CAND: begin
                    cand_reg  <= cand_next;
                    beat_reg  <= beat_next;
                    state_reg <= S_LOAD_P;
                end
                S_EMIT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_level_reg  <= pulse_reg;
                        m_upd_reg    <= upd_reg;
                        if (upd_reg) begin
                            last_pulse_reg <= pulse_reg;
                            ticks_reg      <= ticks_next;
                            held_avg_reg   <= held_next;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TDATA_OUT_W'(m_level_reg);
    assign m_tuser  = m_upd_reg;

endmodule
